/* rtl/core/set_assoc_writeback_cache_tags_defines.svh */
// ---------------------------------------------------------------------------
// Assertion macros for the cache tag block
// ---------------------------------------------------------------------------
`ifndef SET_ASSOC_WRITEBACK_CACHE_TAGS_DEFINES_SVH
`define SET_ASSOC_WRITEBACK_CACHE_TAGS_DEFINES_SVH

// same-cycle implication, off during reset
`define SAC_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("cache tags: same-cycle check failed");

// next-cycle implication, off during reset
`define SAC_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("cache tags: next-cycle check failed");

`endif

/* rtl/core/sac_pkg.sv */
// ---------------------------------------------------------------------------
// sac_pkg
// Types and constants shared by the cache tag store modules.
// ---------------------------------------------------------------------------
package sac_pkg;

  localparam int MAX_SETS  = 256;
  localparam int MAX_WAYS  = 8;
  localparam int ADDR_BITS = 32;

  localparam int SET_BITS  = $clog2(MAX_SETS);
  localparam int WAY_BITS  = $clog2(MAX_WAYS);
  localparam int WCNT_BITS = $clog2(MAX_WAYS + 1);
  localparam int CFG_BITS  = 4;
  localparam int CFG_IDX_BITS = 2;

  localparam logic [CFG_BITS-1:0] OFFSET_MAX = CFG_BITS'(12);
  localparam logic [CFG_BITS-1:0] INDEX_MAX  = CFG_BITS'(SET_BITS);

  localparam logic [CFG_BITS-1:0] OFFSET_RST = CFG_BITS'(4);
  localparam logic [CFG_BITS-1:0] INDEX_RST  = CFG_BITS'(4);
  localparam logic [CFG_BITS-1:0] WAYS_RST   = CFG_BITS'(1);

  localparam logic [CFG_IDX_BITS-1:0] REG_BLK_SHIFT   = CFG_IDX_BITS'(0);
  localparam logic [CFG_IDX_BITS-1:0] REG_SET_WIDTH   = CFG_IDX_BITS'(1);
  localparam logic [CFG_IDX_BITS-1:0] REG_WAYS_IN_USE = CFG_IDX_BITS'(2);

  typedef struct packed {
    logic [ADDR_BITS-1:0] tag;
    logic                 valid;
    logic                 dirty;
  } line_t;

  typedef struct packed {
    line_t [MAX_WAYS-1:0] lines;
    logic  [WAY_BITS-1:0] vptr;
  } row_t;

  typedef struct packed {
    logic                hit;
    logic                dirty_evict;
    logic [WAY_BITS-1:0] way;
    row_t                row_next;
  } lookup_t;

  typedef enum logic {
    ST_IDLE,
    ST_LOOKUP
  } state_t;

endpackage

/* rtl/core/sac_req_if.sv */
// ---------------------------------------------------------------------------
// sac_req_if
// Request channel: access address and kind with valid/ready.
// ---------------------------------------------------------------------------
interface sac_req_if import sac_pkg::*; ;
  logic                 valid;
  logic                 ready;
  logic [ADDR_BITS-1:0] addr;
  logic                 mode;

  modport source (output valid, output addr, output mode, input ready);
  modport sink   (input valid, input addr, input mode, output ready);
endinterface

/* rtl/core/sac_rsp_if.sv */
// ---------------------------------------------------------------------------
// sac_rsp_if
// Response channel: hit, write-back and way with valid/ready.
// ---------------------------------------------------------------------------
interface sac_rsp_if import sac_pkg::*; ;
  logic                valid;
  logic                ready;
  logic                hit;
  logic                dirty_evict;
  logic [WAY_BITS-1:0] way;

  modport source (output valid, output hit, output dirty_evict, output way, input ready);
  modport sink   (input valid, input hit, input dirty_evict, input way, output ready);
endinterface

/* rtl/core/set_assoc_writeback_cache_tags.sv */
// ---------------------------------------------------------------------------
// set_assoc_writeback_cache_tags
// Tag store of a set-associative write-back cache: lookup, fill and
// dirty tracking with a round-robin victim pointer per set.
//
//   channel  dir  payload                  handshake
//   req      in   addr[31:0], mode         valid/ready
//   rsp      out  hit, dirty_evict, way    valid/ready
//   wr_*     in   wr_index[1:0], wr_data   wr_en, no stall
//
// The set row is read from the set RAM when the request is accepted, and it is
// compared, updated and written back in the lookup state that follows.
// One request is in flight at a time; the RAM write lands before the next
// read, so no forwarding is needed. Per-set valid flops, cleared by rst,
// make unwritten rows read as empty, so there is no clearing pass.
// The update cycle holds while a response is waiting and rsp.ready is low.
// ---------------------------------------------------------------------------
`include "set_assoc_writeback_cache_tags_defines.svh"

module set_assoc_writeback_cache_tags import sac_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  sac_req_if.sink                 req,
  sac_rsp_if.source               rsp,
  input  logic                    wr_en,
  input  logic [CFG_IDX_BITS-1:0] wr_index,
  input  logic [CFG_BITS-1:0]     wr_data
);

  logic [CFG_BITS-1:0] blk_shift;
  logic [CFG_BITS-1:0] set_width;
  logic [CFG_BITS-1:0] ways_in_use;

  state_t state, state_next;
  logic   accept;
  logic   do_update;

  logic [CFG_BITS-1:0]  off_c;
  logic [CFG_BITS-1:0]  ib_c;
  logic [WCNT_BITS-1:0] ways_c;
  logic [CFG_BITS:0]    tag_sh;
  logic [SET_BITS:0]    set_span;
  logic [SET_BITS-1:0]  set_mask;
  logic [SET_BITS-1:0]  set_in;

  logic [SET_BITS-1:0]  set_q;
  logic [ADDR_BITS-1:0] tag_q;
  logic                 store_q;

  logic [MAX_SETS-1:0]  row_valid;
  logic [$bits(row_t)-1:0] ram_rdata;
  row_t                 row_cur;
  lookup_t              lu;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      blk_shift   <= OFFSET_RST;
      set_width   <= INDEX_RST;
      ways_in_use <= WAYS_RST;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_BLK_SHIFT:   blk_shift   <= wr_data;
        REG_SET_WIDTH:   set_width   <= wr_data;
        REG_WAYS_IN_USE: ways_in_use <= wr_data;
        default: ;
      endcase
    end
  end

  // clamp the split and associativity to what the store holds
  always_comb begin
    off_c = (blk_shift > OFFSET_MAX) ? OFFSET_MAX : blk_shift;
    ib_c  = (set_width > INDEX_MAX) ? INDEX_MAX : set_width;
    if (ways_in_use == '0) begin
      ways_c = WCNT_BITS'(1);
    end else if (ways_in_use > CFG_BITS'(MAX_WAYS)) begin
      ways_c = WCNT_BITS'(MAX_WAYS);
    end else begin
      ways_c = WCNT_BITS'(ways_in_use);
    end
  end

  assign tag_sh   = {1'b0, off_c} + {1'b0, ib_c};
  assign set_span = (SET_BITS + 1)'(1) << ib_c;
  assign set_mask = SET_BITS'(set_span - 1'b1);
  assign set_in   = SET_BITS'(req.addr >> off_c) & set_mask;

  assign accept = req.valid && req.ready;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (req.valid) state_next = ST_LOOKUP;
      ST_LOOKUP: if (!rsp.valid || rsp.ready) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    req.ready = 1'b0;
    do_update = 1'b0;
    unique case (state)
      ST_IDLE:   req.ready = 1'b1;
      ST_LOOKUP: do_update = !rsp.valid || rsp.ready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // capture the request
  always_ff @(posedge clk) begin
    if (accept) begin
      set_q   <= set_in;
      tag_q   <= req.addr >> tag_sh;
      store_q <= req.mode;
    end
  end

  sac_set_ram #(
    .WIDTH ($bits(row_t)),
    .DEPTH (MAX_SETS)
  ) u_set_ram (
    .clk   (clk),
    .we    (do_update),
    .waddr (set_q),
    .wdata (lu.row_next),
    .re    (accept),
    .raddr (set_in),
    .rdata (ram_rdata)
  );

  // rows never written read as empty
  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
    end else if (do_update) begin
      row_valid[set_q] <= 1'b1;
    end
  end

  assign row_cur = row_valid[set_q] ? row_t'(ram_rdata) : '0;

  sac_way_match u_way_match (
    .row    (row_cur),
    .tag    (tag_q),
    .store  (store_q),
    .ways   (ways_c),
    .result (lu)
  );

  // response register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (do_update) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (do_update) begin
      rsp.hit         <= lu.hit;
      rsp.dirty_evict <= lu.dirty_evict;
      rsp.way         <= lu.way;
    end
  end

  `SAC_ASSERT_NEXT(a_accept_to_lookup, clk, rst, accept, state == ST_LOOKUP)
  `SAC_ASSERT_NEXT(a_update_gives_rsp, clk, rst, do_update, rsp.valid && row_valid[set_q])
  `SAC_ASSERT_NOW(a_hit_no_evict, clk, rst, do_update && lu.hit, !lu.dirty_evict)
  `SAC_ASSERT_NOW(a_way_in_range, clk, rst, do_update, WCNT_BITS'(lu.way) < ways_c)

endmodule

/* rtl/core/sac_set_ram.sv */
// ---------------------------------------------------------------------------
// sac_set_ram
// Simple dual-port RAM, one write and one registered read per cycle.
// ---------------------------------------------------------------------------
module sac_set_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/core/sac_way_match.sv */
// ---------------------------------------------------------------------------
// sac_way_match
// Compares the tag against every way in use of a set, picks the hit or victim way
// and builds the updated set row.
// ---------------------------------------------------------------------------
module sac_way_match import sac_pkg::*; (
  input  row_t                 row,
  input  logic [ADDR_BITS-1:0] tag,
  input  logic                 store,
  input  logic [WCNT_BITS-1:0] ways,
  output lookup_t              result
);

  logic                 hit;
  logic [WAY_BITS-1:0]  found;
  logic [WAY_BITS-1:0]  victim;
  logic [WCNT_BITS-1:0] vsum;

  always_comb begin
    hit   = 1'b0;
    found = '0;
    // lowest matching way wins
    for (int w = 0; w < MAX_WAYS; w++) begin
      if (!hit && (WCNT_BITS'(w) < ways) && row.lines[w].valid &&
          (row.lines[w].tag == tag)) begin
        hit   = 1'b1;
        found = WAY_BITS'(w);
      end
    end
  end

  always_comb begin
    if (hit) begin
      victim = found;
    end else if (WCNT_BITS'(row.vptr) >= ways) begin
      victim = '0;
    end else begin
      victim = row.vptr;
    end
    vsum = WCNT_BITS'(victim) + 1'b1;
  end

  always_comb begin
    result.hit         = hit;
    result.dirty_evict = 1'b0;
    result.way         = victim;
    result.row_next    = row;
    if (hit) begin
      if (store) begin
        result.row_next.lines[victim].dirty = 1'b1;
      end
    end else begin
      result.dirty_evict                  = row.lines[victim].dirty;
      result.row_next.lines[victim].tag   = tag;
      result.row_next.lines[victim].valid = 1'b1;
      result.row_next.lines[victim].dirty = store;
    end
    result.row_next.vptr = (vsum == ways) ? '0 : WAY_BITS'(vsum);
  end

endmodule
